FILE: src/rmq_pkg.sv
// rmq_pkg: shared types, widths and arithmetic steps for the rotation
// matrix to quaternion converter
// no dependencies
`timescale 1ns / 1ps

package rmq_pkg;

  // field and datapath widths
  localparam int QW       = 16;   // Q2.14 word
  localparam int ARG_W    = 18;   // trace and pivot argument, signed
  localparam int RAD_W    = 30;   // radicand arg*4096, padded to an even width
  localparam int SQ_STEPS = RAD_W / 2;
  localparam int ROOT_W   = SQ_STEPS;
  localparam int SQR_W    = 18;   // square root remainder
  localparam int D_W      = 17;   // off-diagonal sum or difference, signed
  localparam int MAG_W    = 17;
  localparam int NUM_W    = 30;   // mag*8192 + p
  localparam int QUO_W    = 23;   // quotient bits left after the top 7
  localparam int DIV_W    = 16;   // divisor 2p
  localparam int LANES    = 3;
  localparam int Q_DEPTH  = 4;
  localparam int QPTR_W   = $clog2(Q_DEPTH);
  localparam int QCNT_W   = $clog2(Q_DEPTH + 1);
  localparam logic signed [ARG_W-1:0] ARG_ONE = ARG_W'(16384);

  typedef enum logic [1:0] {SEL_X, SEL_Y, SEL_Z, SEL_W} sel_t;

  // classified word from front to back
  typedef struct packed {
    sel_t                  sel;
    logic                  deg;
    logic [RAD_W-1:0]      rad;
    logic signed [D_W-1:0] da;
    logic signed [D_W-1:0] db;
    logic signed [D_W-1:0] dc;
  } fwd_t;

  // queue status
  typedef struct packed {
    logic              full;
    logic              empty;
    logic [QCNT_W-1:0] count;
  } q_status_t;

  // square root stage contents
  typedef struct packed {
    sel_t                  sel;
    logic                  deg;
    logic [RAD_W-1:0]      rad;
    logic [SQR_W-1:0]      rem;
    logic [ROOT_W-1:0]     res;
    logic signed [D_W-1:0] da;
    logic signed [D_W-1:0] db;
    logic signed [D_W-1:0] dc;
  } sq_t;

  // one divider lane
  typedef struct packed {
    logic             neg;
    logic [NUM_W-1:0] num;
    logic [DIV_W-1:0] rem;
    logic [QUO_W-1:0] quo;
  } lane_t;

  // divider stage contents
  typedef struct packed {
    sel_t                     sel;
    logic                     deg;
    logic [ROOT_W-1:0]        p;
    lane_t [LANES-1:0]        ln;
  } dv_t;

  // one digit of the integer square root, pair index from the top
  function automatic sq_t sqrt_step(sq_t s, int step);
    sq_t              o;
    logic [1:0]       pair;
    logic [SQR_W+1:0] cand;
    logic [SQR_W+1:0] trial;
    o     = s;
    pair  = 2'((s.rad >> (2 * (SQ_STEPS - 1 - step))) & RAD_W'(3));
    cand  = {s.rem, pair};
    trial = (SQR_W + 2)'({s.res, 2'b01});
    if (cand >= trial) begin
      o.rem = SQR_W'(cand - trial);
      o.res = {s.res[ROOT_W-2:0], 1'b1};
    end else begin
      o.rem = SQR_W'(cand);
      o.res = {s.res[ROOT_W-2:0], 1'b0};
    end
    return o;
  endfunction

  // one quotient bit of the restoring divider
  function automatic lane_t div_step(lane_t l, logic [DIV_W-1:0] dv, int step);
    lane_t            o;
    logic [DIV_W:0]   cand;
    o    = l;
    cand = {l.rem, l.num[QUO_W-1-step]};
    if (cand >= {1'b0, dv}) begin
      o.rem = DIV_W'(cand - {1'b0, dv});
      o.quo = {l.quo[QUO_W-2:0], 1'b1};
    end else begin
      o.rem = DIV_W'(cand);
      o.quo = {l.quo[QUO_W-2:0], 1'b0};
    end
    return o;
  endfunction

  // signed result with saturation from sign and magnitude
  function automatic logic [QW-1:0] sat_q(logic neg, logic [QUO_W-1:0] q);
    logic [QW-1:0] r;
    if (!neg) begin
      r = (q > QUO_W'(32767)) ? QW'(32767) : q[QW-1:0];
    end else begin
      r = (q > QUO_W'(32768)) ? QW'(32768) : QW'(-q[QW-1:0]);
    end
    return r;
  endfunction

endpackage

FILE: src/rmq_front.sv
// rmq_front: branch choice, pivot argument and off-diagonal terms
// depends on rmq_pkg
`timescale 1ns / 1ps

module rmq_front import rmq_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  logic              push,
  input  logic [QW-1:0]     r00, r01, r02,
  input  logic [QW-1:0]     r10, r11, r12,
  input  logic [QW-1:0]     r20, r21, r22,
  output logic              word_valid,
  output fwd_t              word
);

  logic signed [ARG_W-1:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;
  logic signed [ARG_W-1:0] trace, arg;
  logic signed [ARG_W-1:0] d_a, d_b, d_c;
  sel_t                    sel;
  fwd_t                    word_next;

  // sign extension
  assign m00 = ARG_W'(signed'(r00));
  assign m01 = ARG_W'(signed'(r01));
  assign m02 = ARG_W'(signed'(r02));
  assign m10 = ARG_W'(signed'(r10));
  assign m11 = ARG_W'(signed'(r11));
  assign m12 = ARG_W'(signed'(r12));
  assign m20 = ARG_W'(signed'(r20));
  assign m21 = ARG_W'(signed'(r21));
  assign m22 = ARG_W'(signed'(r22));
  assign trace = m00 + m11 + m22;

  // pick the pivot and the three other terms in output order
  always_comb begin
    priority if (trace > 0) begin
      sel = SEL_W;
      arg = trace + ARG_ONE;
      d_a = m21 - m12;
      d_b = m02 - m20;
      d_c = m10 - m01;
    end else if (m00 > m11 && m00 > m22) begin
      sel = SEL_X;
      arg = m00 - m11 - m22 + ARG_ONE;
      d_a = m10 + m01;
      d_b = m02 + m20;
      d_c = m21 - m12;
    end else if (m11 > m22) begin
      sel = SEL_Y;
      arg = m11 - m00 - m22 + ARG_ONE;
      d_a = m10 + m01;
      d_b = m21 + m12;
      d_c = m02 - m20;
    end else begin
      sel = SEL_Z;
      arg = m22 - m00 - m11 + ARG_ONE;
      d_a = m02 + m20;
      d_b = m21 + m12;
      d_c = m10 - m01;
    end
    word_next.sel = sel;
    word_next.deg = (arg <= 0);
    word_next.rad = (arg <= 0) ? '0 : RAD_W'({arg[ARG_W-2:0], 12'b0});
    word_next.da  = D_W'(d_a);
    word_next.db  = D_W'(d_b);
    word_next.dc  = D_W'(d_c);
  end

  // holding register
  always_ff @(posedge clk) begin
    if (rst) begin
      word_valid <= 1'b0;
    end else if (load) begin
      word_valid <= 1'b1;
    end else if (push) begin
      word_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      word <= word_next;
    end
  end

endmodule

FILE: src/rmq_queue.sv
// rmq_queue: short word queue between front and back
// depends on rmq_pkg
`timescale 1ns / 1ps

module rmq_queue import rmq_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  fwd_t      wr_word,
  input  logic      pop,
  output fwd_t      rd_word,
  output q_status_t status
);

  fwd_t              mem [Q_DEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QCNT_W-1:0] count;

  assign status.count = count;
  assign status.full  = (count == QCNT_W'(Q_DEPTH));
  assign status.empty = (count == '0);
  assign rd_word      = mem[rd_ptr];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_word;
    end
  end

endmodule

FILE: src/rmq_back.sv
// rmq_back: pipelined square root, three divider lanes and output assembly
// depends on rmq_pkg
`timescale 1ns / 1ps

module rmq_back import rmq_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  fwd_t          in_word,
  output logic          done,
  output logic [QW-1:0] quat_x,
  output logic [QW-1:0] quat_y,
  output logic [QW-1:0] quat_z,
  output logic [QW-1:0] quat_w,
  output logic          degenerate
);

  sq_t  sq_in  [SQ_STEPS];
  sq_t  sq     [SQ_STEPS];
  logic sq_v   [SQ_STEPS];
  dv_t  dv_in  [QUO_W];
  dv_t  dv     [QUO_W];
  logic dv_v   [QUO_W];
  logic signed [D_W-1:0] dsel [LANES];
  logic [MAG_W-1:0]      mag  [LANES];
  logic [QW-1:0]         qa, qb, qc, pv;
  dv_t                   last;

  // square root stage inputs
  always_comb begin
    sq_in[0].sel = in_word.sel;
    sq_in[0].deg = in_word.deg;
    sq_in[0].rad = in_word.rad;
    sq_in[0].rem = '0;
    sq_in[0].res = '0;
    sq_in[0].da  = in_word.da;
    sq_in[0].db  = in_word.db;
    sq_in[0].dc  = in_word.dc;
    for (int s = 1; s < SQ_STEPS; s++) begin
      sq_in[s] = sq[s-1];
    end
  end

  // square root stages, one root bit each
  always_ff @(posedge clk) begin
    for (int s = 0; s < SQ_STEPS; s++) begin
      sq[s] <= sqrt_step(sq_in[s], s);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < SQ_STEPS; s++) begin
        sq_v[s] <= 1'b0;
      end
    end else begin
      sq_v[0] <= in_valid;
      for (int s = 1; s < SQ_STEPS; s++) begin
        sq_v[s] <= sq_v[s-1];
      end
    end
  end

  // divider setup: sign, magnitude and numerator mag*8192 + p
  always_comb begin
    dsel[0] = sq[SQ_STEPS-1].da;
    dsel[1] = sq[SQ_STEPS-1].db;
    dsel[2] = sq[SQ_STEPS-1].dc;
    dv_in[0].sel = sq[SQ_STEPS-1].sel;
    dv_in[0].deg = sq[SQ_STEPS-1].deg;
    dv_in[0].p   = sq[SQ_STEPS-1].res;
    for (int l = 0; l < LANES; l++) begin
      mag[l] = dsel[l][D_W-1] ? MAG_W'(-dsel[l]) : MAG_W'(dsel[l]);
      dv_in[0].ln[l].neg = dsel[l][D_W-1];
      dv_in[0].ln[l].num = {mag[l], 13'b0} + NUM_W'(sq[SQ_STEPS-1].res);
      dv_in[0].ln[l].rem = DIV_W'(dv_in[0].ln[l].num[NUM_W-1:QUO_W]);
      dv_in[0].ln[l].quo = '0;
    end
    for (int j = 1; j < QUO_W; j++) begin
      dv_in[j] = dv[j-1];
    end
  end

  // divider stages, one quotient bit each
  always_ff @(posedge clk) begin
    for (int j = 0; j < QUO_W; j++) begin
      dv[j].sel <= dv_in[j].sel;
      dv[j].deg <= dv_in[j].deg;
      dv[j].p   <= dv_in[j].p;
      for (int l = 0; l < LANES; l++) begin
        dv[j].ln[l] <= div_step(dv_in[j].ln[l], {dv_in[j].p, 1'b0}, j);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j < QUO_W; j++) begin
        dv_v[j] <= 1'b0;
      end
    end else begin
      dv_v[0] <= sq_v[SQ_STEPS-1];
      for (int j = 1; j < QUO_W; j++) begin
        dv_v[j] <= dv_v[j-1];
      end
    end
  end

  // saturate and place components
  assign last = dv[QUO_W-1];
  assign qa   = sat_q(last.ln[0].neg, last.ln[0].quo);
  assign qb   = sat_q(last.ln[1].neg, last.ln[1].quo);
  assign qc   = sat_q(last.ln[2].neg, last.ln[2].quo);
  assign pv   = QW'(last.p);

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= dv_v[QUO_W-1];
    end
  end

  always_ff @(posedge clk) begin
    degenerate <= last.deg;
    if (last.deg) begin
      quat_x <= '0;
      quat_y <= '0;
      quat_z <= '0;
      quat_w <= '0;
    end else begin
      unique case (last.sel)
        SEL_W: begin
          quat_x <= qa; quat_y <= qb; quat_z <= qc; quat_w <= pv;
        end
        SEL_X: begin
          quat_x <= pv; quat_y <= qa; quat_z <= qb; quat_w <= qc;
        end
        SEL_Y: begin
          quat_x <= qa; quat_y <= pv; quat_z <= qb; quat_w <= qc;
        end
        default: begin
          quat_x <= qa; quat_y <= qb; quat_z <= pv; quat_w <= qc;
        end
      endcase
    end
  end

endmodule

FILE: src/rotation_matrix_to_quaternion.sv
// rotation_matrix_to_quaternion: top level, front classifier, queue, back
// depends on rmq_pkg, rmq_front, rmq_queue, rmq_back
//
// channel   direction  handshake      payload
// command   in         start / busy   r00 .. r22
// result    out        done strobe    quat_x quat_y quat_z quat_w degenerate
//
// one word accepted per cycle while busy is low; each result strobes done
// after passing the registers listed below, in command order, one per
// cycle at full rate
// registers on the path: front 1 (loads at the command edge), queue 1,
// square root 15 (one root bit per stage), divider 23 (one quotient bit per
// stage, three lanes), output 1
// rst is synchronous and empties every stage; the result side cannot stall,
// so the back drains the queue every cycle and busy stays low in practice
`timescale 1ns / 1ps

module rotation_matrix_to_quaternion import rmq_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  logic [QW-1:0] r00, r01, r02,
  input  logic [QW-1:0] r10, r11, r12,
  input  logic [QW-1:0] r20, r21, r22,
  output logic          done,
  output logic [QW-1:0] quat_x,
  output logic [QW-1:0] quat_y,
  output logic [QW-1:0] quat_z,
  output logic [QW-1:0] quat_w,
  output logic          degenerate
);

  logic      load, push, pop, f_valid;
  fwd_t      f_word, q_word;
  q_status_t q_stat;

  // handshake
  assign busy = f_valid && q_stat.full;
  assign load = start && !busy;
  assign push = f_valid && !q_stat.full;
  assign pop  = !q_stat.empty;

  rmq_front u_front (
    .clk        (clk),
    .rst        (rst),
    .load       (load),
    .push       (push),
    .r00        (r00), .r01 (r01), .r02 (r02),
    .r10        (r10), .r11 (r11), .r12 (r12),
    .r20        (r20), .r21 (r21), .r22 (r22),
    .word_valid (f_valid),
    .word       (f_word)
  );

  rmq_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .wr_word (f_word),
    .pop     (pop),
    .rd_word (q_word),
    .status  (q_stat)
  );

  rmq_back u_back (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (pop),
    .in_word    (q_word),
    .done       (done),
    .quat_x     (quat_x),
    .quat_y     (quat_y),
    .quat_z     (quat_z),
    .quat_w     (quat_w),
    .degenerate (degenerate)
  );

  // a degenerate word carries all-zero components
  a_deg_zero: assert property (@(posedge clk) disable iff (rst)
    done && degenerate |-> (quat_x == '0) && (quat_y == '0) &&
                           (quat_z == '0) && (quat_w == '0))
    else $error("degenerate result with nonzero component");

  // the back drains every cycle, so the queue never fills
  a_no_fill: assert property (@(posedge clk) disable iff (rst)
    !q_stat.full)
    else $error("queue filled although the back never stalls");

  // fill count follows push and pop
  a_count: assert property (@(posedge clk) disable iff (rst)
    $past(!rst) && !$past(push) && !$past(pop) |-> $stable(q_stat.count))
    else $error("queue count moved without push or pop");

endmodule
